@@ rtl/core/aar_pkg.sv @@
// shared widths, types and constants for the axis-angle point rotator
package aar_pkg;

	localparam int FRAC_BITS = 16;

	// field widths
	localparam int CFG_W = 18;
	localparam int PT_W  = 32;
	localparam int D_W   = PT_W + 1;
	localparam int IDX_W = 4;
	localparam int DATA_W = 32;

	// coefficient datapath widths
	localparam int K_W   = ((CFG_W > FRAC_BITS + 1) ? CFG_W : FRAC_BITS + 1) + 1;
	localparam int KP_W  = K_W + CFG_W;
	localparam int KA_W  = KP_W - FRAC_BITS;
	localparam int SP_W  = 2 * CFG_W;
	localparam int SA_W  = SP_W - FRAC_BITS;
	localparam int PP_W  = KA_W + CFG_W;
	localparam int P_W   = PP_W - FRAC_BITS;
	localparam int E_MAX = (P_W > SA_W) ? ((P_W > CFG_W) ? P_W : CFG_W)
		: ((SA_W > CFG_W) ? SA_W : CFG_W);
	localparam int E_W   = E_MAX + 1;
	localparam int COEF_W = 29;
	localparam int CMP_W = ((E_W > COEF_W) ? E_W : COEF_W) + 1;

	// point datapath widths: the difference is split for two narrow multipliers
	localparam int D_LO_W = 17;
	localparam int D_HI_W = D_W - D_LO_W;
	localparam int LO_W   = COEF_W + D_LO_W + 1;
	localparam int HI_W   = COEF_W + D_HI_W;
	localparam int FULL_W = COEF_W + D_W;
	localparam int TERM_W = FULL_W - FRAC_BITS;
	localparam int SUM_W  = ((TERM_W > PT_W) ? TERM_W : PT_W) + 2;

	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);
	localparam int QC_W   = QA_W + 1;

	// cycles for a new register value to reach the matrix
	localparam int SETTLE   = 3;
	localparam int SETTLE_W = 2;

	localparam logic signed [K_W-1:0]   ONE_K     = K_W'(1) << FRAC_BITS;
	localparam logic signed [CFG_W-1:0] ONE_RESET = CFG_W'(65536);
	localparam logic [PT_W-1:0] PT_MAX = {1'b0, {(PT_W - 1){1'b1}}};
	localparam logic [PT_W-1:0] PT_MIN = {1'b1, {(PT_W - 1){1'b0}}};

	// register indexes
	localparam logic [IDX_W-1:0] REG_COS   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_SIN   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_AX    = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_AY    = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_AZ    = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_PIV_X = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_PIV_Y = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_PIV_Z = IDX_W'(7);

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		coef_t [8:0]            m;
		logic [2:0][PT_W-1:0]   pivot;
	} xform_t;

	typedef struct packed {
		logic [2:0][D_W-1:0] d;
	} delta_t;

endpackage

@@ rtl/core/aar_if.sv @@
// stream and configuration channel interfaces

interface aar_in_if;
	logic                      valid;
	logic                      ready;
	logic [aar_pkg::PT_W-1:0]  in_x;
	logic [aar_pkg::PT_W-1:0]  in_y;
	logic [aar_pkg::PT_W-1:0]  in_z;
	modport source (output valid, output in_x, output in_y, output in_z, input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface aar_out_if;
	logic                      valid;
	logic                      ready;
	logic [aar_pkg::PT_W-1:0]  out_x;
	logic [aar_pkg::PT_W-1:0]  out_y;
	logic [aar_pkg::PT_W-1:0]  out_z;
	logic                      saturated;
	modport source (output valid, output out_x, output out_y, output out_z,
		output saturated, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input saturated, output ready);
endinterface

interface aar_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [aar_pkg::IDX_W-1:0]   index;
	logic [aar_pkg::DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/aar_coef.sv @@
// configuration registers and the pipeline that builds the rotation matrix
module aar_coef (
	input  logic            clk,
	input  logic            arst_n,
	aar_cfg_if.sink         cfg,
	output aar_pkg::xform_t xform,
	output logic            settled
);

	logic signed [aar_pkg::CFG_W-1:0] cos_q;
	logic signed [aar_pkg::CFG_W-1:0] sin_q;
	logic signed [aar_pkg::CFG_W-1:0] axis_q [3];
	logic [2:0][aar_pkg::PT_W-1:0]    piv_q;
	logic [aar_pkg::SETTLE_W-1:0]     settle_q;
	logic                             wr;

	logic signed [aar_pkg::K_W-1:0]   k;
	logic signed [aar_pkg::KP_W-1:0]  kp [3];
	logic signed [aar_pkg::SP_W-1:0]  sp [3];

	logic signed [aar_pkg::KA_W-1:0]  ka_s1 [3];
	logic signed [aar_pkg::SA_W-1:0]  sa_s1 [3];
	logic signed [aar_pkg::CFG_W-1:0] c_s1;

	logic signed [aar_pkg::P_W-1:0]   p_s2 [6];
	logic signed [aar_pkg::SA_W-1:0]  sa_s2 [3];
	logic signed [aar_pkg::CFG_W-1:0] c_s2;

	logic signed [aar_pkg::E_W-1:0]   e [9];
	aar_pkg::coef_t [8:0]             m_s3;

	// products of the axis pairs, in this order
	localparam int PXX = 0;
	localparam int PYY = 1;
	localparam int PZZ = 2;
	localparam int PXY = 3;
	localparam int PXZ = 4;
	localparam int PYZ = 5;

	function automatic logic signed [aar_pkg::P_W-1:0] scale_pair(
		input logic signed [aar_pkg::KA_W-1:0]  a,
		input logic signed [aar_pkg::CFG_W-1:0] b
	);
		logic signed [aar_pkg::PP_W-1:0] p;
		p = aar_pkg::PP_W'(a) * aar_pkg::PP_W'(b);
		return p[aar_pkg::PP_W-1:aar_pkg::FRAC_BITS];
	endfunction

	function automatic aar_pkg::coef_t clamp_coef(input logic signed [aar_pkg::E_W-1:0] v);
		localparam logic signed [aar_pkg::CMP_W-1:0] CMAX =
			(aar_pkg::CMP_W'(1) << (aar_pkg::COEF_W - 1)) - aar_pkg::CMP_W'(1);
		localparam logic signed [aar_pkg::CMP_W-1:0] CMIN = ~CMAX;
		logic signed [aar_pkg::CMP_W-1:0] w;
		logic signed [aar_pkg::CMP_W-1:0] r;
		w = aar_pkg::CMP_W'(v);
		if (w > CMAX) begin
			r = CMAX;
		end else if (w < CMIN) begin
			r = CMIN;
		end else begin
			r = w;
		end
		return r[aar_pkg::COEF_W-1:0];
	endfunction

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;
	assign settled   = (settle_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q     <= aar_pkg::ONE_RESET;
			sin_q     <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= aar_pkg::ONE_RESET;
			piv_q     <= '0;
			settle_q  <= aar_pkg::SETTLE_W'(aar_pkg::SETTLE);
		end else begin
			if (wr) begin
				// matrix stages refill after any write
				settle_q <= aar_pkg::SETTLE_W'(aar_pkg::SETTLE);
				unique case (cfg.index)
					aar_pkg::REG_COS:   cos_q     <= cfg.data[aar_pkg::CFG_W-1:0];
					aar_pkg::REG_SIN:   sin_q     <= cfg.data[aar_pkg::CFG_W-1:0];
					aar_pkg::REG_AX:    axis_q[0] <= cfg.data[aar_pkg::CFG_W-1:0];
					aar_pkg::REG_AY:    axis_q[1] <= cfg.data[aar_pkg::CFG_W-1:0];
					aar_pkg::REG_AZ:    axis_q[2] <= cfg.data[aar_pkg::CFG_W-1:0];
					aar_pkg::REG_PIV_X: piv_q[0]  <= cfg.data[aar_pkg::PT_W-1:0];
					aar_pkg::REG_PIV_Y: piv_q[1]  <= cfg.data[aar_pkg::PT_W-1:0];
					aar_pkg::REG_PIV_Z: piv_q[2]  <= cfg.data[aar_pkg::PT_W-1:0];
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
		end
	end

	// stage 1: (1 - cos) * a and sin * a
	always_comb begin
		k = aar_pkg::ONE_K - aar_pkg::K_W'(cos_q);
		for (int i = 0; i < 3; i++) begin
			kp[i] = aar_pkg::KP_W'(k) * aar_pkg::KP_W'(axis_q[i]);
			sp[i] = aar_pkg::SP_W'(sin_q) * aar_pkg::SP_W'(axis_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ka_s1[i] <= kp[i][aar_pkg::KP_W-1:aar_pkg::FRAC_BITS];
			sa_s1[i] <= sp[i][aar_pkg::SP_W-1:aar_pkg::FRAC_BITS];
		end
		c_s1 <= cos_q;
	end

	// stage 2: pair products
	always_ff @(posedge clk) begin
		p_s2[PXX] <= scale_pair(ka_s1[0], axis_q[0]);
		p_s2[PYY] <= scale_pair(ka_s1[1], axis_q[1]);
		p_s2[PZZ] <= scale_pair(ka_s1[2], axis_q[2]);
		p_s2[PXY] <= scale_pair(ka_s1[0], axis_q[1]);
		p_s2[PXZ] <= scale_pair(ka_s1[0], axis_q[2]);
		p_s2[PYZ] <= scale_pair(ka_s1[1], axis_q[2]);
		sa_s2     <= sa_s1;
		c_s2      <= c_s1;
	end

	// stage 3: matrix entries
	always_comb begin
		e[0] = aar_pkg::E_W'(c_s2)      + aar_pkg::E_W'(p_s2[PXX]);
		e[1] = aar_pkg::E_W'(p_s2[PXY]) - aar_pkg::E_W'(sa_s2[2]);
		e[2] = aar_pkg::E_W'(p_s2[PXZ]) + aar_pkg::E_W'(sa_s2[1]);
		e[3] = aar_pkg::E_W'(p_s2[PXY]) + aar_pkg::E_W'(sa_s2[2]);
		e[4] = aar_pkg::E_W'(c_s2)      + aar_pkg::E_W'(p_s2[PYY]);
		e[5] = aar_pkg::E_W'(p_s2[PYZ]) - aar_pkg::E_W'(sa_s2[0]);
		e[6] = aar_pkg::E_W'(p_s2[PXZ]) - aar_pkg::E_W'(sa_s2[1]);
		e[7] = aar_pkg::E_W'(p_s2[PYZ]) + aar_pkg::E_W'(sa_s2[0]);
		e[8] = aar_pkg::E_W'(c_s2)      + aar_pkg::E_W'(p_s2[PZZ]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			m_s3[i] <= clamp_coef(e[i]);
		end
	end

	assign xform.m     = m_s3;
	assign xform.pivot = piv_q;

endmodule

@@ rtl/core/aar_front.sv @@
// input side: takes points, removes the pivot and queues the differences
module aar_front (
	input  logic                      clk,
	input  logic                      arst_n,
	aar_in_if.sink                    in_pt,
	input  logic                      settled,
	input  logic [2:0][aar_pkg::PT_W-1:0] pivot,
	output logic                      q_valid,
	output aar_pkg::delta_t           q_data,
	input  logic                      q_pop
);

	aar_pkg::delta_t              q_mem [aar_pkg::QDEPTH];
	aar_pkg::delta_t              wdata;
	logic [aar_pkg::QA_W-1:0]     wr_ptr_q;
	logic [aar_pkg::QA_W-1:0]     rd_ptr_q;
	logic [aar_pkg::QC_W-1:0]     count_q;
	logic                         push;
	logic                         pop;
	logic [aar_pkg::PT_W-1:0]     in_pt_v [3];

	assign in_pt_v[0] = in_pt.in_x;
	assign in_pt_v[1] = in_pt.in_y;
	assign in_pt_v[2] = in_pt.in_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wdata.d[i] = aar_pkg::D_W'($signed(in_pt_v[i])) - aar_pkg::D_W'($signed(pivot[i]));
		end
	end

	assign in_pt.ready = settled && (count_q != aar_pkg::QC_W'(aar_pkg::QDEPTH));
	assign push        = in_pt.valid && in_pt.ready;
	assign q_valid     = (count_q != '0);
	assign pop         = q_pop && q_valid;
	assign q_data      = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/aar_back.sv @@
// output side: matrix times difference, pivot added back, saturation
module aar_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  aar_pkg::delta_t q_data,
	output logic            q_pop,
	input  aar_pkg::xform_t xform,
	aar_out_if.source       out_pt
);

	logic                             adv;
	logic                             v_s1, v_s2, v_s3, v_s4;
	logic signed [aar_pkg::LO_W-1:0]  lo [3][3];
	logic signed [aar_pkg::HI_W-1:0]  hi [3][3];
	logic signed [aar_pkg::LO_W-1:0]  lo_s1 [3][3];
	logic signed [aar_pkg::HI_W-1:0]  hi_s1 [3][3];
	logic signed [aar_pkg::FULL_W-1:0] full [3][3];
	logic signed [aar_pkg::TERM_W-1:0] term_s2 [3][3];
	logic signed [aar_pkg::SUM_W-1:0] sum [3];
	logic signed [aar_pkg::SUM_W-1:0] sum_s3 [3];
	logic [aar_pkg::PT_W-1:0]         res [3];
	logic [2:0]                       clip;
	logic [aar_pkg::PT_W-1:0]         res_s4 [3];
	logic                             sat_s4;

	localparam logic signed [aar_pkg::SUM_W-1:0] SUM_MAX =
		aar_pkg::SUM_W'(aar_pkg::PT_MAX);
	localparam logic signed [aar_pkg::SUM_W-1:0] SUM_MIN = ~SUM_MAX;

	// whole pipeline moves unless the output register holds an untaken result
	assign adv   = !v_s4 || out_pt.ready;
	assign q_pop = adv;

	// stage 1: split partial products
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				lo[r][c] = aar_pkg::LO_W'($signed(xform.m[r * 3 + c]))
					* aar_pkg::LO_W'($signed({1'b0, q_data.d[c][aar_pkg::D_LO_W-1:0]}));
				hi[r][c] = aar_pkg::HI_W'($signed(xform.m[r * 3 + c]))
					* aar_pkg::HI_W'($signed(q_data.d[c][aar_pkg::D_W-1:aar_pkg::D_LO_W]));
			end
		end
	end

	// stage 2: join partials, shift out fraction
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				full[r][c] = (aar_pkg::FULL_W'(hi_s1[r][c]) <<< aar_pkg::D_LO_W)
					+ aar_pkg::FULL_W'(lo_s1[r][c]);
			end
		end
	end

	// stage 3: row sums plus pivot
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = aar_pkg::SUM_W'($signed(xform.pivot[r]))
				+ aar_pkg::SUM_W'(term_s2[r][0])
				+ aar_pkg::SUM_W'(term_s2[r][1])
				+ aar_pkg::SUM_W'(term_s2[r][2]);
		end
	end

	// stage 4: clip to 32 bits
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (sum_s3[r] > SUM_MAX) begin
				res[r]  = aar_pkg::PT_MAX;
				clip[r] = 1'b1;
			end else if (sum_s3[r] < SUM_MIN) begin
				res[r]  = aar_pkg::PT_MIN;
				clip[r] = 1'b1;
			end else begin
				res[r]  = sum_s3[r][aar_pkg::PT_W-1:0];
				clip[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s1 <= lo;
			hi_s1 <= hi;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					term_s2[r][c] <= full[r][c][aar_pkg::FULL_W-1:aar_pkg::FRAC_BITS];
				end
			end
			sum_s3 <= sum;
			res_s4 <= res;
			sat_s4 <= |clip;
		end
	end

	assign out_pt.valid     = v_s4;
	assign out_pt.out_x     = res_s4[0];
	assign out_pt.out_y     = res_s4[1];
	assign out_pt.out_z     = res_s4[2];
	assign out_pt.saturated = sat_s4;

endmodule

@@ rtl/core/axis_angle_rotate_about_point_top.sv @@
// an accepted point is written into the queue and then moves through the stage registers
// throughput: one point per cycle while the output is taken, set by the
// four-stage multiply pipeline behind a four-entry queue; the queue keeps taking
// points while a result waits; reset and every register write hold input
// ready low while the matrix pipeline reloads; reset clears all control state
module axis_angle_rotate_about_point_top (
	input  logic      clk,
	input  logic      arst_n,
	aar_in_if.sink    in_pt,
	aar_out_if.source out_pt,
	aar_cfg_if.sink   cfg
);

	aar_pkg::xform_t xform;
	aar_pkg::delta_t q_data;
	logic            settled;
	logic            q_valid;
	logic            q_pop;

	aar_coef u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.xform   (xform),
		.settled (settled)
	);

	aar_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_pt   (in_pt),
		.settled (settled),
		.pivot   (xform.pivot),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	aar_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.xform   (xform),
		.out_pt  (out_pt)
	);

endmodule

@@ rtl/core/aar_checker.sv @@
// port-level checks for the rotator, bound to the top level
module aar_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [aar_pkg::PT_W-1:0] out_x,
	input logic [aar_pkg::PT_W-1:0] out_y,
	input logic [aar_pkg::PT_W-1:0] out_z,
	input logic                     out_sat,
	input logic                     cfg_valid,
	input logic                     cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(out_sat))
		else $error("output changed while stalled");

	// clip flag only with a coordinate at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sat |-> out_x == aar_pkg::PT_MAX || out_x == aar_pkg::PT_MIN
			|| out_y == aar_pkg::PT_MAX || out_y == aar_pkg::PT_MIN
			|| out_z == aar_pkg::PT_MAX || out_z == aar_pkg::PT_MIN)
		else $error("saturated flag without clipped coordinate");

	// input held off while the matrix reloads
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken before matrix reload finished");

endmodule

bind axis_angle_rotate_about_point_top aar_checker u_aar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_pt.ready),
	.out_valid (out_pt.valid),
	.out_ready (out_pt.ready),
	.out_x     (out_pt.out_x),
	.out_y     (out_pt.out_y),
	.out_z     (out_pt.out_z),
	.out_sat   (out_pt.saturated),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
